// ----- rtl/badt_pkg.sv -----
package badt_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int ENTRY_W       = 10;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int STORE_W       = ENTRY_W + 1;
   localparam int DEPTH_MAX     = 16;
   localparam int IDX_W         = $clog2(DEPTH_MAX);
   localparam int LEN_W         = $clog2(DEPTH_MAX + 1);
   localparam int LIMIT_W       = 5;
   localparam int DIST_W        = 6;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START_A,
      S_WALK_A,
      S_START_B,
      S_WALK_B,
      S_DIRECT,
      S_PAIR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic rec_write;
      logic load;
      logic set_equal;
      logic start;
      logic walk;
      logic sel_b;
      logic direct;
      logic pair_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic equal;
      logic start_more;
      logic walk_more;
      logic direct_hit;
      logic len_a_zero;
      logic pair_hit;
      logic pair_last;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/badt_ram.sv -----
module badt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/badt_ctrl.sv -----
module badt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   output logic              req_ready,
   output badt_pkg::cmd_type cmd,
   input  badt_pkg::sts_type sts
);
   import badt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_RECORD) begin
                  cmd.rec_write = 1'b1;
               end else if (sts.equal) begin
                  cmd.set_equal = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_START_A;
               end
            end
         end
         S_START_A: begin
            cmd.start = 1'b1;
            state_in  = sts.start_more ? S_WALK_A : S_START_B;
         end
         S_WALK_A: begin
            cmd.walk = 1'b1;
            if (!sts.walk_more) begin
               state_in = S_START_B;
            end
         end
         S_START_B: begin
            cmd.start = 1'b1;
            cmd.sel_b = 1'b1;
            state_in  = sts.start_more ? S_WALK_B : S_DIRECT;
         end
         S_WALK_B: begin
            cmd.walk  = 1'b1;
            cmd.sel_b = 1'b1;
            if (!sts.walk_more) begin
               state_in = S_DIRECT;
            end
         end
         S_DIRECT: begin
            cmd.direct = 1'b1;
            if (sts.direct_hit || sts.len_a_zero) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PAIR;
            end
         end
         S_PAIR: begin
            cmd.pair_step = 1'b1;
            if (sts.pair_hit || sts.pair_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/badt_dp.sv -----
module badt_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  badt_pkg::cmd_type                 cmd,
   output badt_pkg::sts_type                 sts,
   input  logic [badt_pkg::ENTRY_W-1:0]      req_first,
   input  logic [badt_pkg::ENTRY_W-1:0]      req_second,
   input  logic                              req_absent,
   input  logic                              csr_valid,
   input  logic [badt_pkg::LIMIT_W-1:0]      csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_related,
   output logic [badt_pkg::DIST_W-1:0]       rsp_distance
);
   import badt_pkg::*;

   logic [LIMIT_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [ENTRY_W-1:0] e1_ff, e1_in, e2_ff, e2_in;
   logic [ENTRY_W-1:0] chain_a_ff [DEPTH_MAX];
   logic [ENTRY_W-1:0] chain_a_in [DEPTH_MAX];
   logic [ENTRY_W-1:0] chain_b_ff [DEPTH_MAX];
   logic [ENTRY_W-1:0] chain_b_in [DEPTH_MAX];
   logic [LEN_W-1:0]   len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic               found_ff, found_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_related_ff, rsp_related_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   logic [LEN_W-1:0]   lim;
   logic [LEN_W-1:0]   cur_len;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [STORE_W-1:0] ram_wr_data, ram_rd_data;
   logic [ENTRY_W-1:0] rd_entry;
   logic               rd_live;
   logic               hit_a, hit_b, hit_p;
   logic [IDX_W-1:0]   idx_a, idx_b, idx_p;
   logic [ENTRY_W-1:0] cur_a;

   badt_ram #(
      .WIDTH (STORE_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_parent_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign lim = (depth_ff > LIMIT_W'(DEPTH_MAX)) ? LEN_W'(DEPTH_MAX) : LEN_W'(depth_ff);
   assign cur_len  = cmd.sel_b ? len_b_ff : len_a_ff;
   assign rd_entry = ram_rd_data[ENTRY_W-1:0];
   assign rd_live  = ram_rd_data[ENTRY_W];
   assign cur_a    = chain_a_ff[i_ff];

   // The store is written by the clearing pass after reset and by record items.
   assign ram_we      = cmd.clr_step | cmd.rec_write;
   assign ram_wr_addr = cmd.clr_step ? clr_addr_ff : req_first[ADDR_W-1:0];
   assign ram_wr_data = (cmd.clr_step || req_absent) ? '0 : {1'b1, req_second};

   // A walk step reads the parent of the element that has just arrived.
   always_comb begin
      if (cmd.start) begin
         ram_rd_addr = cmd.sel_b ? e2_ff[ADDR_W-1:0] : e1_ff[ADDR_W-1:0];
      end else begin
         ram_rd_addr = rd_entry[ADDR_W-1:0];
      end
   end

   // First matching position, lowest index winning, in each compare group.
   always_comb begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      hit_p = 1'b0;
      idx_a = '0;
      idx_b = '0;
      idx_p = '0;
      for (int j = DEPTH_MAX - 1; j >= 0; j--) begin
         if ((LEN_W'(j) < len_a_ff) && (chain_a_ff[j] == e2_ff)) begin
            hit_a = 1'b1;
            idx_a = IDX_W'(j);
         end
         if ((LEN_W'(j) < len_b_ff) && (chain_b_ff[j] == e1_ff)) begin
            hit_b = 1'b1;
            idx_b = IDX_W'(j);
         end
         if ((LEN_W'(j) < len_b_ff) && (chain_b_ff[j] == cur_a)) begin
            hit_p = 1'b1;
            idx_p = IDX_W'(j);
         end
      end
   end

   always_comb begin
      sts.clr_last   = (clr_addr_ff == ADDR_W'(TABLE_ENTRIES - 1));
      sts.equal      = (req_first == req_second);
      sts.start_more = (lim > LEN_W'(1));
      sts.walk_more  = rd_live && (LEN_W'(cur_len + LEN_W'(1)) < lim);
      sts.direct_hit = hit_a | hit_b;
      sts.len_a_zero = (len_a_ff == '0);
      sts.pair_hit   = hit_p;
      sts.pair_last  = (LEN_W'(i_ff) + LEN_W'(1) >= len_a_ff);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      depth_in       = csr_valid ? csr_data : depth_ff;
      clr_addr_in    = cmd.clr_step ? ADDR_W'(clr_addr_ff + ADDR_W'(1)) : clr_addr_ff;
      e1_in          = cmd.load ? req_first : e1_ff;
      e2_in          = cmd.load ? req_second : e2_ff;
      chain_a_in     = chain_a_ff;
      chain_b_in     = chain_b_ff;
      len_a_in       = len_a_ff;
      len_b_in       = len_b_ff;
      i_in           = i_ff;
      found_in       = found_ff;
      dist_in        = dist_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_related_in = rsp_related_ff;
      rsp_dist_in    = rsp_dist_ff;

      if (cmd.start) begin
         if (cmd.sel_b) begin
            chain_b_in[0] = e2_ff;
            len_b_in      = (lim != '0) ? LEN_W'(1) : '0;
         end else begin
            chain_a_in[0] = e1_ff;
            len_a_in      = (lim != '0) ? LEN_W'(1) : '0;
         end
      end

      if (cmd.walk && rd_live) begin
         if (cmd.sel_b) begin
            chain_b_in[cur_len[IDX_W-1:0]] = rd_entry;
            len_b_in = LEN_W'(len_b_ff + LEN_W'(1));
         end else begin
            chain_a_in[cur_len[IDX_W-1:0]] = rd_entry;
            len_a_in = LEN_W'(len_a_ff + LEN_W'(1));
         end
      end

      if (cmd.set_equal) begin
         found_in = 1'b1;
         dist_in  = '0;
      end

      if (cmd.direct) begin
         found_in = hit_a | hit_b;
         i_in     = '0;
         if (hit_b) begin
            dist_in = DIST_W'(idx_b) + DIST_W'(1);
         end else if (hit_a) begin
            dist_in = DIST_W'(idx_a) + DIST_W'(1);
         end else begin
            dist_in = '0;
         end
      end

      if (cmd.pair_step) begin
         i_in = IDX_W'(i_ff + IDX_W'(1));
         if (hit_p) begin
            found_in = 1'b1;
            dist_in  = DIST_W'(i_ff) + DIST_W'(idx_p) + DIST_W'(2);
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_related_in = found_ff;
         rsp_dist_in    = found_ff ? dist_ff : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= LIMIT_RESET;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         i_ff         <= '0;
         found_ff     <= 1'b0;
         dist_ff      <= '0;
      end else begin
         depth_ff     <= depth_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         i_ff         <= i_in;
         found_ff     <= found_in;
         dist_ff      <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff          <= e1_in;
      e2_ff          <= e2_in;
      chain_a_ff     <= chain_a_in;
      chain_b_ff     <= chain_b_in;
      rsp_related_ff <= rsp_related_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_related  = rsp_related_ff;
   assign rsp_distance = rsp_dist_ff;

endmodule

// ----- rtl/bounded_ancestor_distance_table_top.sv -----
// Bounded ancestor distance table.
// The req stream carries one item per transfer. A record item (tuser action
// low) stores the parent of first_entry in the parent table and gives no
// result. A query item (action high) gives one rsp
// transfer holding the distance between first_entry and second_entry.
// A query with equal entries skips the walk. The effective depth limit
// (0..16) is the written limit capped at 16; the parent walk reads one
// table entry a cycle from the table RAM, and the pair compare checks one
// first-chain element against the whole second chain a cycle. Items are
// taken one at a time.
// The depth limit is written through the csr channel, which is always ready.
// After reset the parent table is cleared by a pass over all 1024 entries during
// which req_tready stays low; the depth limit returns to 5.
// The result sits in an output register: if the receiver stalls, the next
// item is still accepted and worked on, and the block waits only when a
// second result is ready before the first has been transferred.
module bounded_ancestor_distance_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // first_entry, second_entry, zero pad
   input  logic [1:0]                    req_tuser,  // action, parent_absent
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // distance, zero pad
   output logic [0:0]                    rsp_tuser,  // related
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [badt_pkg::LIMIT_W-1:0]  csr_data
);
   import badt_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic [DIST_W-1:0]  rsp_distance;
   logic               rsp_related;

   badt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser[0]),
      .req_ready  (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   badt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_first    (req_tdata[ENTRY_W-1:0]),
      .req_second   (req_tdata[2*ENTRY_W-1:ENTRY_W]),
      .req_absent   (req_tuser[1]),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_related  (rsp_related),
      .rsp_distance (rsp_distance)
   );

   assign csr_ready    = 1'b1;
   assign rsp_tdata    = {{(8 - DIST_W){1'b0}}, rsp_distance};
   assign rsp_tuser[0] = rsp_related;

endmodule

// ----- sim/bounded_ancestor_distance_table_top_test.sv -----
`timescale 1ns / 100ps

module bounded_ancestor_distance_table_top_test;
   import badt_pkg::*;

   localparam int WINDOW        = 48;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 130;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 64;

   typedef struct packed {
      logic              related;
      logic [DIST_W-1:0] distance;
   } result_type;

   typedef struct packed {
      logic               action;
      logic [ENTRY_W-1:0] first;
      logic [ENTRY_W-1:0] second;
      logic               absent;
      logic               typed;
      result_type         want;
   } step_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [23:0]         req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [7:0]          rsp_tdata;
   logic [0:0]          rsp_tuser;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_data;

   // Predictor state: bit 10 marks a valid parent, bits 9..0 hold it.
   logic [STORE_W-1:0]  parent_link [TABLE_ENTRIES];
   logic [LIMIT_W-1:0]  depth_setting;
   result_type          expected_results [$];
   step_type            plan [$];
   int                  mismatch_count;
   bit                  req_eager;
   bit                  rsp_eager;

   bounded_ancestor_distance_table_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic result_type predict_distance(logic [ENTRY_W-1:0] first,
                                                   logic [ENTRY_W-1:0] second);
      logic [ENTRY_W-1:0] chain [2][DEPTH_MAX];
      int                 len [2];
      int                 lim;
      int                 k;
      int                 i;
      int                 j;
      logic [ENTRY_W-1:0] cur;
      bit                 live;
      result_type         res;
      res = '0;
      if (first == second) begin
         res.related = 1'b1;
         return res;
      end
      lim = (depth_setting > DEPTH_MAX) ? DEPTH_MAX : int'(depth_setting);
      for (k = 0; k < 2; k++) begin
         cur    = (k == 0) ? first : second;
         len[k] = 0;
         live   = 1'b1;
         while (live && len[k] < lim) begin
            chain[k][len[k]] = cur;
            len[k]++;
            if (parent_link[cur][ENTRY_W]) begin
               cur = parent_link[cur][ENTRY_W-1:0];
            end else begin
               live = 1'b0;
            end
         end
      end
      res.related = 1'b1;
      for (i = 0; i < len[1]; i++) begin
         if (chain[1][i] == first) begin
            res.distance = DIST_W'(i + 1);
            return res;
         end
      end
      for (i = 0; i < len[0]; i++) begin
         if (chain[0][i] == second) begin
            res.distance = DIST_W'(i + 1);
            return res;
         end
      end
      for (i = 0; i < len[0]; i++) begin
         for (j = 0; j < len[1]; j++) begin
            if (chain[0][i] == chain[1][j]) begin
               res.distance = DIST_W'(i + j + 2);
               return res;
            end
         end
      end
      return '0;
   endfunction

   function automatic void add_step(logic action, int first, int second, logic absent,
                                    logic typed, logic related, int distance);
      step_type s;
      s.action        = action;
      s.first         = ENTRY_W'(first);
      s.second        = ENTRY_W'(second);
      s.absent        = absent;
      s.typed         = typed;
      s.want.related  = related;
      s.want.distance = DIST_W'(distance);
      plan = {plan, s};
   endfunction

   task automatic report_mismatch(string what, int want, int got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // Entered and left at a falling edge.
   task automatic send_item(logic action, logic [ENTRY_W-1:0] first,
                            logic [ENTRY_W-1:0] second, logic absent,
                            logic typed, result_type typed_want);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, second, first};
      req_tuser  <= {absent, action};
      do @(posedge clock); while (!req_tready);
      if (action == ACT_QUERY) begin
         expected_results = {expected_results,
                             typed ? typed_want : predict_distance(first, second)};
      end else if (absent) begin
         parent_link[first] = '0;
      end else begin
         parent_link[first] = {1'b1, second};
      end
      @(negedge clock);
   endtask

   // A trailing record may still be in flight once the last result has gone.
   task automatic wait_until_drained(int settle);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_depth_limit(logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      depth_setting = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, related", -1, rsp_tuser[0]);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser[0] !== want.related) begin
               report_mismatch("related", want.related, rsp_tuser[0]);
            end
            if (rsp_tdata !== {2'b00, want.distance}) begin
               report_mismatch("distance", want.distance, rsp_tdata);
            end
         end
      end
   end

   initial begin : take_results
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_eager ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : run_sequence
      int         depth_plan [PHASES];
      int         ph;
      int         n;
      int         roll;
      int         base;
      int         child;
      int         parent;
      result_type none;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      mismatch_count = 0;
      req_eager      = 1'b0;
      rsp_eager      = 1'b0;
      none           = '0;
      depth_setting  = LIMIT_RESET;
      foreach (parent_link[k]) parent_link[k] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed part, run at the reset depth limit of five.
      add_step(ACT_QUERY,  0,    1023, 1'b1, 1'b1, 1'b0, 0);   // empty table: unrelated
      add_step(ACT_QUERY,  1023, 1023, 1'b0, 1'b1, 1'b1, 0);
      add_step(ACT_QUERY,  0,    0,    1'b1, 1'b1, 1'b1, 0);
      add_step(ACT_RECORD, 1023, 0,    1'b0, 1'b0, 1'b0, 0);
      add_step(ACT_QUERY,  1023, 0,    1'b0, 1'b0, 1'b0, 0);
      add_step(ACT_QUERY,  0,    1023, 1'b0, 1'b0, 1'b0, 0);
      for (n = 11; n <= 16; n++) begin
         add_step(ACT_RECORD, n, n - 1, 1'b0, 1'b0, 1'b0, 0);
      end
      add_step(ACT_QUERY,  16,   10,   1'b0, 1'b0, 1'b0, 0);   // beyond the depth limit
      add_step(ACT_QUERY,  14,   10,   1'b1, 1'b0, 1'b0, 0);
      add_step(ACT_RECORD, 20,   12,   1'b0, 1'b0, 1'b0, 0);
      add_step(ACT_QUERY,  20,   16,   1'b0, 1'b0, 1'b0, 0);   // common ancestor
      add_step(ACT_RECORD, 11,   1023, 1'b1, 1'b0, 1'b0, 0);   // parent cleared
      add_step(ACT_QUERY,  14,   10,   1'b0, 1'b0, 1'b0, 0);
      add_step(ACT_RECORD, 1023, 1023, 1'b1, 1'b0, 1'b0, 0);
      add_step(ACT_QUERY,  1023, 0,    1'b0, 1'b1, 1'b0, 0);
      add_step(ACT_QUERY,  10,   10,   1'b1, 1'b1, 1'b1, 0);
      foreach (plan[k]) begin
         send_item(plan[k].action, plan[k].first, plan[k].second, plan[k].absent,
                   plan[k].typed, plan[k].want);
      end

      depth_plan = '{16, 1, 0, 31, 8, 17, 2, 5, 0, 16};
      depth_plan[8] = $urandom_range(0, 31);
      for (ph = 0; ph < PHASES; ph++) begin
         wait_until_drained(SETTLE_CYCLES);
         write_depth_limit(LIMIT_W'(depth_plan[ph]));
         if (ph == 0) begin
            base = 0;
         end else if (ph == PHASES - 1) begin
            base = TABLE_ENTRIES - WINDOW;
         end else begin
            base = $urandom_range(0, TABLE_ENTRIES - WINDOW);
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               req_eager = ($urandom_range(0, 3) == 0);
               rsp_eager = ($urandom_range(0, 3) == 0);
            end
            if (n == PHASE_ITEMS / 2 && ph % 3 == 1) begin
               wait_until_drained(1);
            end
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               send_item(1'($urandom_range(0, 1)), ENTRY_W'($urandom), ENTRY_W'($urandom),
                         1'($urandom_range(0, 1)), 1'b0, none);
            end else if (roll < 50) begin
               // Mostly links to the entry just below, so that long chains grow.
               child = base + $urandom_range(0, WINDOW - 1);
               if (child > base && $urandom_range(0, 3) != 0) begin
                  parent = child - 1;
               end else begin
                  parent = base + $urandom_range(0, WINDOW - 1);
               end
               send_item(ACT_RECORD, ENTRY_W'(child), ENTRY_W'(parent),
                         ($urandom_range(0, 9) == 0), 1'b0, none);
            end else begin
               child  = base + $urandom_range(0, WINDOW - 1);
               parent = ($urandom_range(0, 11) == 0) ? child
                                                     : base + $urandom_range(0, WINDOW - 1);
               send_item(ACT_QUERY, ENTRY_W'(child), ENTRY_W'(parent),
                         1'($urandom_range(0, 1)), 1'b0, none);
            end
         end
      end

      wait_until_drained(TAIL_CYCLES);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
